>>> rtl/core/spq_pkg.sv
// Shared types, codes and ranking function for the saturation priority queue.
package spq_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_COLOR   = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_ABSENT = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_DUP    = 3'd4;

  localparam logic [6:0] SAT_MAX = 7'd127;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] node_index;
    logic [5:0] node_degree;
    logic [5:0] color;
  } req_t;

  typedef struct packed {
    logic [5:0] top_node;
    logic [6:0] saturation;
    logic [2:0] status;
  } rsp_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] sat;
    logic [5:0] deg;
    logic [5:0] node;
  } entry_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_PUSH,
    CM_POP
  } cell_mode_t;

  // Broadcast to every cell. PUSH places ent_new in sorted order; with use_old
  // set, the entry equal to ent_old is the one that moves up.
  typedef struct packed {
    cell_mode_t mode;
    logic       use_old;
    entry_t     ent_new;
    entry_t     ent_old;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_UPD
  } state_t;

  // True when a ranks strictly above b.
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.sat != b.sat) r = a.sat > b.sat;
    else if (a.deg != b.deg) r = a.deg > b.deg;
    else r = a.node < b.node;
    return r;
  endfunction

endpackage

>>> rtl/core/spq_ram.sv
// Generic single-address RAM with registered read.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/spq_cell.sv
// One slot of the sorted queue; trades entries with its neighbors.
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    left_ent,
  input  logic      left_below,
  input  entry_t    right_ent,
  output entry_t    ent,
  output logic      below
);

  entry_t ent_r, ent_nxt;
  logic   at_or_above_old;

  assign below = !ent_r.valid || ranks_above(cmd.ent_new, ent_r);
  assign at_or_above_old = cmd.use_old ?
                           (ent_r.valid && !ranks_above(cmd.ent_old, ent_r)) : 1'b1;

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.mode)
      CM_POP: ent_nxt = right_ent;
      CM_PUSH: begin
        if (below && at_or_above_old) ent_nxt = left_below ? left_ent : cmd.ent_new;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r <= '0;
    else ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

>>> rtl/core/saturation_priority_queue_unit.sv
// Top level: DSATUR priority queue built as a sorted row of cells.
//
// channel | ports                  | handshake
// in      | start, busy, in_req    | request taken when start && !busy
// out     | out_valid, out_rsp     | one-cycle strobe, no backpressure
//
// Insert, extract, unused op and a refused add-colour: strobe registered from the EXEC state.
// Accepted add-colour: passes EXEC, READ and UPD, strobe registered from UPD (read of color set
// and saturation memories, then update).
// The cell row reorders in a single registered step; the memory read adds the READ state for add-color.
// Reset is synchronous; memories need no clearing pass.
// busy stays high from accept until the result is registered.
module saturation_priority_queue_unit import spq_pkg::*; #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_COLORS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int CW = $clog2(MAX_COLORS);

  state_t state_r, state_nxt;
  req_t   req_r;
  logic [SW-1:0]        size_r, size_nxt;
  logic [MAX_NODES-1:0] queued_r, queued_nxt;
  logic   out_valid_r, out_valid_nxt;
  rsp_t   rsp_r, rsp_nxt;

  cell_cmd_t cmd;
  entry_t    ents   [MAX_NODES];
  logic      belows [MAX_NODES];

  logic [NW+5:0] node_wide, top_wide;
  logic [NW-1:0] node_addr, top_addr;
  logic          node_ok, queued_hit;
  logic [CW+5:0] color_wide;
  logic [CW-1:0] cidx;
  logic          color_ok, new_bit;
  logic [6:0]    sat_old, sat_new;

  logic                  info_we, seen_we;
  logic [12:0]           info_wd, info_rd;
  logic [MAX_COLORS-1:0] seen_wd, seen_rd;

  assign node_wide  = {{NW{1'b0}}, req_r.node_index};
  assign node_addr  = node_wide[NW-1:0];
  assign node_ok    = node_wide < (NW+6)'(MAX_NODES);
  assign queued_hit = node_ok && queued_r[node_addr];
  assign top_wide   = {{NW{1'b0}}, ents[0].node};
  assign top_addr   = top_wide[NW-1:0];
  assign color_wide = {{CW{1'b0}}, req_r.color};
  assign cidx       = color_wide[CW-1:0];
  assign color_ok   = color_wide < (CW+6)'(MAX_COLORS);
  assign sat_old    = info_rd[12:6];
  assign sat_new    = (sat_old == SAT_MAX) ? SAT_MAX : sat_old + 7'd1;
  assign new_bit    = color_ok && !seen_rd[cidx];

  spq_ram #(.WIDTH(13), .DEPTH(MAX_NODES)) u_info (
    .clk(clk), .we(info_we), .addr(node_addr), .wdata(info_wd), .rdata(info_rd)
  );

  spq_ram #(.WIDTH(MAX_COLORS), .DEPTH(MAX_NODES)) u_seen (
    .clk(clk), .we(seen_we), .addr(node_addr), .wdata(seen_wd), .rdata(seen_rd)
  );

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    entry_t l_ent, r_ent;
    logic   l_below;
    if (i == 0) begin : g_first
      assign l_ent   = '0;
      assign l_below = 1'b0;
    end else begin : g_mid
      assign l_ent   = ents[i-1];
      assign l_below = belows[i-1];
    end
    if (i == MAX_NODES - 1) begin : g_last
      assign r_ent = '0;
    end else begin : g_inner
      assign r_ent = ents[i+1];
    end
    spq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .left_ent(l_ent), .left_below(l_below), .right_ent(r_ent),
      .ent(ents[i]), .below(belows[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    queued_nxt    = queued_r;
    out_valid_nxt = 1'b0;
    rsp_nxt       = '0;
    info_we       = 1'b0;
    seen_we       = 1'b0;
    info_wd       = {7'd0, req_r.node_degree};
    seen_wd       = '0;
    cmd           = '0;
    cmd.mode      = CM_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        rsp_nxt.status = ST_OK;
        unique case (req_r.op)
          OP_INSERT: begin
            if (queued_hit) begin
              rsp_nxt.status = ST_DUP;
            end else if (!node_ok || size_r == SW'(MAX_NODES)) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              info_we = 1'b1;
              seen_we = 1'b1;
              queued_nxt[node_addr] = 1'b1;
              size_nxt = size_r + SW'(1);
              cmd.mode = CM_PUSH;
              cmd.ent_new = '{valid: 1'b1, sat: 7'd0, deg: req_r.node_degree,
                              node: req_r.node_index};
            end
          end
          OP_EXTRACT: begin
            if (size_r == '0) begin
              rsp_nxt.status = ST_EMPTY;
            end else begin
              rsp_nxt.top_node   = ents[0].node;
              rsp_nxt.saturation = ents[0].sat;
              queued_nxt[top_addr] = 1'b0;
              size_nxt = size_r - SW'(1);
              cmd.mode = CM_POP;
            end
          end
          OP_COLOR: begin
            if (size_r == '0) begin
              rsp_nxt.status = ST_EMPTY;
            end else if (!queued_hit) begin
              rsp_nxt.status = ST_ABSENT;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt = S_READ;
            end
          end
          default: rsp_nxt.status = ST_OK;
        endcase
      end
      S_READ: state_nxt = S_UPD;
      S_UPD: begin
        state_nxt          = S_IDLE;
        out_valid_nxt      = 1'b1;
        rsp_nxt.status     = ST_OK;
        rsp_nxt.saturation = sat_old;
        if (new_bit) begin
          seen_we = 1'b1;
          seen_wd = seen_rd | (MAX_COLORS'(1) << cidx);
          info_we = 1'b1;
          info_wd = {sat_new, info_rd[5:0]};
          rsp_nxt.saturation = sat_new;
          cmd.mode    = CM_PUSH;
          cmd.use_old = 1'b1;
          cmd.ent_new = '{valid: 1'b1, sat: sat_new, deg: info_rd[5:0],
                          node: req_r.node_index};
          cmd.ent_old = '{valid: 1'b1, sat: sat_old, deg: info_rd[5:0],
                          node: req_r.node_index};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) req_r <= in_req;
    rsp_r <= rsp_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

`ifndef SYNTHESIS
  a_size_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    size_r == SW'($countones(queued_r)))
    else $error("queue size disagrees with queued flags");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r != '0) == ents[0].valid)
    else $error("head cell validity disagrees with queue size");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC || state_r == S_UPD))
    else $error("result strobe without a request in progress");
`endif

endmodule

>>> bench/saturation_priority_queue_unit_test.sv
// Self-checking bench for the saturation priority queue: directed table, then random requests.
module saturation_priority_queue_unit_test import spq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 64;
  localparam int N_RANDOM = 200;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  saturation_priority_queue_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // shadow heap state
  logic [5:0] slot_node [NODES];
  logic [5:0] node_slot [NODES];
  logic       queued [NODES];
  logic [6:0] sat_of [NODES];
  logic [5:0] deg_of [NODES];
  logic [63:0] colors_of [NODES];
  int unsigned heap_cnt;

  rsp_t pending_rsp [$];
  int errors;

  function automatic bit outranks(logic [5:0] a, logic [5:0] b);
    if (sat_of[a] != sat_of[b]) return sat_of[a] > sat_of[b];
    if (deg_of[a] != deg_of[b]) return deg_of[a] > deg_of[b];
    return a < b;
  endfunction

  function automatic void exchange(int unsigned i, int unsigned j);
    logic [5:0] a, b;
    a = slot_node[i];
    b = slot_node[j];
    slot_node[i] = b;
    slot_node[j] = a;
    node_slot[b] = i[5:0];
    node_slot[a] = j[5:0];
  endfunction

  function automatic void bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(slot_node[i], slot_node[p])) break;
      exchange(i, p);
      i = p;
    end
  endfunction

  function automatic void bubble_down(int unsigned i);
    int unsigned l, r, best;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < heap_cnt && outranks(slot_node[l], slot_node[best])) best = l;
      if (r < heap_cnt && outranks(slot_node[r], slot_node[best])) best = r;
      if (best == i) break;
      exchange(i, best);
      i = best;
    end
  endfunction

  function automatic rsp_t queue_step(req_t q);
    rsp_t o;
    logic [5:0] n, last;
    o = '0;
    o.status = ST_OK;
    n = q.node_index;
    if (q.op == OP_INSERT) begin
      if (queued[n]) o.status = ST_DUP;
      else if (heap_cnt >= NODES) o.status = ST_FULL;
      else begin
        sat_of[n] = '0;
        deg_of[n] = q.node_degree;
        colors_of[n] = '0;
        queued[n] = 1'b1;
        slot_node[heap_cnt] = n;
        node_slot[n] = heap_cnt[5:0];
        heap_cnt++;
        bubble_up(heap_cnt - 1);
      end
    end else if (q.op == OP_EXTRACT) begin
      if (heap_cnt == 0) o.status = ST_EMPTY;
      else begin
        o.top_node = slot_node[0];
        o.saturation = sat_of[slot_node[0]];
        queued[slot_node[0]] = 1'b0;
        heap_cnt--;
        if (heap_cnt > 0) begin
          last = slot_node[heap_cnt];
          slot_node[0] = last;
          node_slot[last] = '0;
          bubble_down(0);
        end
      end
    end else if (q.op == OP_COLOR) begin
      if (heap_cnt == 0) o.status = ST_EMPTY;
      else if (!queued[n]) o.status = ST_ABSENT;
      else begin
        if (!colors_of[n][q.color]) begin
          colors_of[n][q.color] = 1'b1;
          if (sat_of[n] < SAT_MAX) sat_of[n]++;
          bubble_up(node_slot[n]);
        end
        o.saturation = sat_of[n];
      end
    end
    return o;
  endfunction

  // directed table; check = 1 means expected value is typed in
  typedef struct {
    req_t rq;
    bit   check;
    rsp_t rs;
  } vec_t;

  vec_t dir_vecs [$];

  task automatic add_vec(logic [1:0] op, logic [5:0] n, logic [5:0] d, logic [5:0] c,
                         bit chk, logic [5:0] t, logic [6:0] s, logic [2:0] st);
    vec_t v;
    v.rq = '{op: op, node_index: n, node_degree: d, color: c};
    v.check = chk;
    v.rs = '{top_node: t, saturation: s, status: st};
    dir_vecs.push_back(v);
  endtask

  bit idle_on;

  // start stays high between back-to-back requests; dropped only while idling or after the last request
  task automatic send(req_t q, bit chk, rsp_t typed);
    rsp_t p;
    while (idle_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    p = queue_step(q);
    if (chk && p != typed) begin
      $display("%0t typed row disagrees: expected %p predicted %p", $time, typed, p);
      errors++;
    end
    pending_rsp.push_back(p);
    start <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, out_rsp);
        errors++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (out_rsp.top_node !== e.top_node)
          $display("%0t top_node: expected %0d actual %0d", $time, e.top_node, out_rsp.top_node);
        if (out_rsp.saturation !== e.saturation)
          $display("%0t saturation: expected %0d actual %0d", $time, e.saturation,
                   out_rsp.saturation);
        if (out_rsp.status !== e.status)
          $display("%0t status: expected %0d actual %0d", $time, e.status, out_rsp.status);
        if (out_rsp !== e) errors++;
      end
    end
  end

  function automatic req_t rand_req();
    req_t q;
    int unsigned k;
    q.node_index = 6'($urandom_range(63));
    q.node_degree = 6'($urandom_range(63));
    q.color = 6'($urandom_range(63));
    k = $urandom_range(99);
    if (k < 2) q.op = OP_UNUSED;
    else if (k < 40) q.op = OP_INSERT;
    else if (k < 62) q.op = OP_EXTRACT;
    else q.op = OP_COLOR;
    // mostly target queued nodes with add-colour
    if (q.op == OP_COLOR && heap_cnt > 0 && k < 95)
      q.node_index = slot_node[$urandom_range(heap_cnt - 1)];
    return q;
  endfunction

  initial begin
    rsp_t none;
    req_t q;
    int waited;
    none = '0;
    errors = 0;
    heap_cnt = 0;
    idle_on = 1'b1;
    for (int i = 0; i < NODES; i++) begin
      queued[i] = 1'b0;
      sat_of[i] = '0;
      deg_of[i] = '0;
      colors_of[i] = '0;
      slot_node[i] = '0;
      node_slot[i] = '0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_vec(OP_EXTRACT, 0, 0, 0, 1, 0, 0, ST_EMPTY);
    add_vec(OP_COLOR, 5, 0, 9, 1, 0, 0, ST_EMPTY);
    add_vec(OP_UNUSED, 63, 63, 63, 1, 0, 0, ST_OK);
    add_vec(OP_INSERT, 63, 63, 0, 1, 0, 0, ST_OK);
    add_vec(OP_INSERT, 63, 1, 0, 1, 0, 0, ST_DUP);
    add_vec(OP_INSERT, 0, 0, 0, 1, 0, 0, ST_OK);
    add_vec(OP_INSERT, 42, 63, 0, 1, 0, 0, ST_OK);
    add_vec(OP_COLOR, 7, 0, 3, 1, 0, 0, ST_ABSENT);
    add_vec(OP_COLOR, 0, 0, 63, 1, 0, 1, ST_OK);
    add_vec(OP_COLOR, 0, 0, 63, 1, 0, 1, ST_OK);
    add_vec(OP_COLOR, 0, 0, 0, 1, 0, 2, ST_OK);
    add_vec(OP_COLOR, 42, 0, 21, 0, 0, 0, ST_OK);
    add_vec(OP_EXTRACT, 0, 0, 0, 1, 0, 2, ST_OK);
    add_vec(OP_EXTRACT, 0, 0, 0, 0, 0, 0, ST_OK);
    add_vec(OP_EXTRACT, 0, 0, 0, 1, 63, 0, ST_OK);
    add_vec(OP_EXTRACT, 0, 0, 0, 1, 0, 0, ST_EMPTY);
    foreach (dir_vecs[i]) send(dir_vecs[i].rq, dir_vecs[i].check, dir_vecs[i].rs);

    // fill to capacity, then a duplicate check
    for (int i = 0; i < NODES; i++) begin
      q = '{op: OP_INSERT, node_index: i[5:0], node_degree: 6'($urandom_range(63)),
            color: 6'($urandom_range(63))};
      send(q, 0, none);
    end
    send('{op: OP_INSERT, node_index: 6'd17, node_degree: 6'd5, color: 6'd0}, 1,
         '{top_node: 0, saturation: 0, status: ST_DUP});
    for (int i = 0; i < 120; i++) begin
      q = '{op: OP_COLOR, node_index: 6'($urandom_range(63)),
            node_degree: 6'($urandom_range(63)), color: 6'($urandom_range(63))};
      send(q, 0, none);
    end
    repeat (NODES / 2) send('{op: OP_EXTRACT, node_index: 0, node_degree: 0, color: 0},
                            0, none);

    for (int i = 0; i < N_RANDOM; i++) begin
      idle_on = !(i >= 60 && i < 140);
      send(rand_req(), 0, none);
    end
    idle_on = 1'b1;
    while (heap_cnt > 0) send('{op: OP_EXTRACT, node_index: 0, node_degree: 0, color: 0},
                              0, none);
    start <= 1'b0;

    waited = 0;
    while (pending_rsp.size() > 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_cell.sv
rtl/core/saturation_priority_queue_unit.sv
bench/saturation_priority_queue_unit_test.sv
